// ===== rtl/core/plb_pkg.sv =====
package plb_pkg;

	localparam int WIN_W  = 4;
	localparam int STR_W  = 3;
	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int SLOT_W = 3;
	localparam int IDX_W  = 3;
	localparam int DAT_W  = 9;
	localparam int QDEPTH = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_POOL_MODE     = 3'd0,
		REG_WINDOW_SIZE   = 3'd1,
		REG_STRIDE        = 3'd2,
		REG_PLANE_COLUMNS = 3'd3,
		REG_PLANE_ROWS    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             max_mode;
		logic [WIN_W-1:0] win;
	} pool_cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ROW_W-1:0]  row0;
		logic [COL_W-1:0]  col0;
		logic              last;
	} job_t;

endpackage

// ===== rtl/core/pooling_2d_max_avg.sv =====
// channel  dir  handshake               payload
// in       in   in_valid / in_stall     sample
// out      out  out_valid / out_stall   pooled_value, max_row, max_column, last_in_plane
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A sample is taken when the job queue has room; at the first column of a row input stalls
// until the window scanner is idle and the job queue is empty, since the new row reuses
// line store slots. A window is completed by the one-read-per-cycle line store scan and,
// in average mode, by the bit-serial divider.
// Reset clears control state only; the line store needs no clearing pass.
module pooling_2d_max_avg import plb_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_WINDOW  = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DAT_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [15:0]            pooled_value,
	output logic [7:0]             max_row,
	output logic [7:0]             max_column,
	output logic                   last_in_plane
);

	logic                   q_full, q_empty, q_push, q_pop, back_idle;
	job_t                   push_job, pop_job;
	logic                   wr_en;
	logic [SLOT_W-1:0]      wr_slot;
	logic [COL_W-1:0]       wr_col;
	logic [SAMPLE_BITS-1:0] wr_data;
	pool_cfg_t              cfg;

	plb_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.q_full   (q_full),
		.back_idle(back_idle && q_empty),
		.q_push   (q_push),
		.q_job    (push_job),
		.wr_en    (wr_en),
		.wr_slot  (wr_slot),
		.wr_col   (wr_col),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	plb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.pop_job (pop_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	plb_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.wr_en        (wr_en),
		.wr_slot      (wr_slot),
		.wr_col       (wr_col),
		.wr_data      (wr_data),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.idle         (back_idle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pooled_value (pooled_value),
		.max_row      (max_row),
		.max_column   (max_column),
		.last_in_plane(last_in_plane)
	);

endmodule

// ===== rtl/core/plb_front.sv =====
module plb_front import plb_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_WINDOW  = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DAT_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   q_full,
	input  logic                   back_idle,
	output logic                   q_push,
	output job_t                   q_job,
	output logic                   wr_en,
	output logic [SLOT_W-1:0]      wr_slot,
	output logic [COL_W-1:0]       wr_col,
	output logic [SAMPLE_BITS-1:0] wr_data,
	output pool_cfg_t              cfg
);

	logic             mode_q;
	logic [2:0]       win_q;
	logic [STR_W-1:0] str_q;
	logic [8:0]       pcols_q;
	logic [8:0]       prows_q;

	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [SLOT_W-1:0] slot_q;
	logic [8:0]        nrs_q;
	logic [9:0]        ncs_q;

	logic [WIN_W-1:0] w_eff;
	logic [STR_W-1:0] s_eff;
	logic [9:0]       cols_eff;
	logic [9:0]       rows_eff;
	logic [9:0]       rp1, cp1;
	logic             row_ok, col_ok, acc, cfg_hit;

	always_comb begin
		if (win_q == 3'd0)
			w_eff = WIN_W'(1);
		else if (32'(win_q) > MAX_WINDOW)
			w_eff = WIN_W'(MAX_WINDOW);
		else
			w_eff = WIN_W'(win_q);
		s_eff = (str_q == '0) ? STR_W'(1) : str_q;
		if (pcols_q == 9'd0)
			cols_eff = 10'd1;
		else if (32'(pcols_q) > MAX_COLUMNS)
			cols_eff = 10'(MAX_COLUMNS);
		else
			cols_eff = {1'b0, pcols_q};
		if (prows_q == 9'd0)
			rows_eff = 10'd1;
		else if (prows_q > 9'd256)
			rows_eff = 10'd256;
		else
			rows_eff = {1'b0, prows_q};
	end

	assign rp1    = 10'(r_q) + 10'd1;
	assign cp1    = 10'(c_q) + 10'd1;
	assign row_ok = (rp1 >= 10'(w_eff)) && ((rp1 - 10'(w_eff)) == 10'(nrs_q));
	assign col_ok = (cp1 >= 10'(w_eff)) && ((cp1 - 10'(w_eff)) == ncs_q);

	// a new row may overwrite slots still being scanned
	assign in_stall = q_full || ((c_q == '0) && !back_idle);
	assign acc      = in_valid && !in_stall;

	assign wr_en   = acc;
	assign wr_slot = slot_q;
	assign wr_col  = c_q;
	assign wr_data = sample;

	assign q_push     = acc && row_ok && col_ok;
	assign q_job.slot = slot_q;
	assign q_job.row0 = ROW_W'(rp1 - 10'(w_eff));
	assign q_job.col0 = COL_W'(cp1 - 10'(w_eff));
	assign q_job.last = ((11'(cp1) + 11'(s_eff)) > 11'(cols_eff)) &&
	                    ((11'(rp1) + 11'(s_eff)) > 11'(rows_eff));

	assign cfg_ready    = 1'b1;
	assign cfg.max_mode = mode_q;
	assign cfg.win      = w_eff;

	always_comb begin
		case (cfg_index)
			REG_POOL_MODE, REG_WINDOW_SIZE, REG_STRIDE,
			REG_PLANE_COLUMNS, REG_PLANE_ROWS: cfg_hit = cfg_valid;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			win_q   <= 3'd2;
			str_q   <= 3'd2;
			pcols_q <= 9'd256;
			prows_q <= 9'd256;
			r_q     <= '0;
			c_q     <= '0;
			slot_q  <= '0;
			nrs_q   <= '0;
			ncs_q   <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_POOL_MODE:     mode_q  <= cfg_data[0];
				REG_WINDOW_SIZE:   win_q   <= cfg_data[2:0];
				REG_STRIDE:        str_q   <= cfg_data[STR_W-1:0];
				REG_PLANE_COLUMNS: pcols_q <= cfg_data;
				REG_PLANE_ROWS:    prows_q <= cfg_data;
				default:           mode_q  <= mode_q;
			endcase
			r_q    <= '0;
			c_q    <= '0;
			slot_q <= '0;
			nrs_q  <= '0;
			ncs_q  <= '0;
		end else if (acc) begin
			if (cp1 == cols_eff) begin
				c_q   <= '0;
				ncs_q <= '0;
				if (rp1 == rows_eff) begin
					r_q    <= '0;
					slot_q <= '0;
					nrs_q  <= '0;
				end else begin
					r_q    <= ROW_W'(rp1);
					slot_q <= (32'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + 1'b1;
					if (row_ok)
						nrs_q <= nrs_q + 9'(s_eff);
				end
			end else begin
				c_q <= COL_W'(cp1);
				if (col_ok)
					ncs_q <= ncs_q + 10'(s_eff);
			end
		end
	end

endmodule

// ===== rtl/core/plb_queue.sv =====
module plb_queue import plb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(QDEPTH);

	job_t          ent_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full    = (cnt_q == (PW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/plb_back.sv =====
module plb_back import plb_pkg::*; #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_WINDOW  = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pool_cfg_t              cfg,
	input  logic                   wr_en,
	input  logic [SLOT_W-1:0]      wr_slot,
	input  logic [COL_W-1:0]       wr_col,
	input  logic [SAMPLE_BITS-1:0] wr_data,
	input  logic                   q_empty,
	input  job_t                   q_job,
	output logic                   q_pop,
	output logic                   idle,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [15:0]            pooled_value,
	output logic [7:0]             max_row,
	output logic [7:0]             max_column,
	output logic                   last_in_plane
);

	localparam int DEPTH = MAX_WINDOW * MAX_COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUMW  = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW) + 1;
	localparam int RW    = $clog2(MAX_WINDOW * MAX_WINDOW) + 1;
	localparam int CW    = $clog2(SUMW + 1);
	localparam int VW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIVLD, ST_DIV, ST_FIN} st_t;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	st_t               st_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col0_q, col_q;
	logic [WIN_W-1:0]  i_q, j_q;
	logic              last_q;

	logic                    rv_s1, first_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [COL_W-1:0]        col_s1;
	logic [SAMPLE_BITS-1:0]  rdata_s1;

	logic signed [SUMW-1:0]        sum_q;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [ROW_W-1:0]              brow_q;
	logic [COL_W-1:0]              bcol_q;

	logic [SUMW-1:0] mag_q;
	logic [RW-1:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            neg_q;

	logic [AW-1:0]                 waddr, raddr;
	logic signed [SAMPLE_BITS-1:0] v;
	logic [RW-1:0]                 dvs, rem_sh;
	logic [SUMW-1:0]               quo;
	logic signed [SAMPLE_BITS-1:0] avg;
	logic signed [VW-1:0]          res;
	logic                          out_free;

	assign waddr = AW'(32'(wr_slot) * MAX_COLUMNS) + AW'(wr_col);
	assign raddr = AW'(32'(slot_q) * MAX_COLUMNS) + AW'(col_q);
	assign v     = $signed(rdata_s1);
	assign dvs   = RW'(cfg.win) * RW'(cfg.win);
	assign rem_sh = {rem_q[RW-2:0], mag_q[SUMW-1]};
	assign quo   = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign avg   = $signed(quo[SAMPLE_BITS-1:0]);
	assign res   = VW'(cfg.max_mode ? best_q : avg);

	assign idle     = (st_q == ST_IDLE);
	assign q_pop    = idle && !q_empty;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wr_data;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			rv_s1     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && st_q != ST_FIN)
				out_valid <= 1'b0;
			rv_s1 <= (st_q == ST_SCAN);
			if (rv_s1) begin
				if (first_s1 || v > best_q) begin
					best_q <= v;
					brow_q <= row_s1;
					bcol_q <= col_s1;
				end
				sum_q <= first_s1 ? SUMW'(v) : sum_q + SUMW'(v);
			end
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						slot_q <= (32'(q_job.slot) >= 32'(cfg.win) - 1) ?
						          SLOT_W'(q_job.slot - SLOT_W'(cfg.win - 1'b1)) :
						          SLOT_W'(32'(q_job.slot) + MAX_WINDOW - 32'(cfg.win) + 1);
						row_q  <= q_job.row0;
						col0_q <= q_job.col0;
						col_q  <= q_job.col0;
						last_q <= q_job.last;
						i_q    <= '0;
						j_q    <= '0;
						st_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					first_s1 <= (i_q == '0) && (j_q == '0);
					row_s1   <= row_q;
					col_s1   <= col_q;
					if (j_q == cfg.win - 1'b1) begin
						j_q    <= '0;
						col_q  <= col0_q;
						i_q    <= i_q + 1'b1;
						row_q  <= row_q + 1'b1;
						slot_q <= (32'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + 1'b1;
						if (i_q == cfg.win - 1'b1)
							st_q <= ST_DRAIN;
					end else begin
						j_q   <= j_q + 1'b1;
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: st_q <= cfg.max_mode ? ST_FIN : ST_DIVLD;
				ST_DIVLD: begin
					neg_q <= sum_q[SUMW-1];
					mag_q <= sum_q[SUMW-1] ? (~sum_q + 1'b1) : sum_q;
					rem_q <= '0;
					cnt_q <= CW'(SUMW);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= dvs) begin
						rem_q <= rem_sh - dvs;
						mag_q <= {mag_q[SUMW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						mag_q <= {mag_q[SUMW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1))
						st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						pooled_value  <= res[15:0];
						max_row       <= cfg.max_mode ? brow_q : '0;
						max_column    <= cfg.max_mode ? bcol_q[7:0] : '0;
						last_in_plane <= last_q;
						st_q          <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
